// File: rtl/sef_pkg.sv
`default_nettype none
package sef_pkg;

    localparam int PRICE_BITS = 32;
    localparam int WL_W       = 9;
    localparam int WT_W       = 16;
    localparam int IDX_W      = 10;
    localparam int CFG_AW     = 2;
    localparam int CFG_DW     = 16;

    localparam logic [CFG_AW-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_AW-1:0] REG_EMA_WEIGHT    = 2'd1;

    localparam logic [WL_W-1:0]  WL_RESET  = 9'd14;
    localparam logic [WT_W-1:0]  WT_RESET  = 16'd8738;
    localparam logic [IDX_W-1:0] INDEX_TOP = 10'd1023;

    // settings seen by front and back
    typedef struct packed {
        logic [WL_W-1:0] win_len;   // effective N, 1..MAX_WINDOW
        logic [WT_W-1:0] weight;
        logic            win_clear; // window_length written this cycle
    } cfg_bus_t;

    // classified valid sample
    typedef struct packed {
        logic [PRICE_BITS-1:0] close;
        logic [31:0]           stamp;
        logic                  emit;
        logic                  seed_ok;
    } q_item_t;

endpackage
`default_nettype wire

// File: rtl/sma_ema_price_filter_top.sv
// A valid beat accepted into an idle engine passes through states READ, UPD, MULB, BLEND,
// DIV and OUT before m_tvalid rises. DIV is a bit-serial divide of the SUM_W-bit window sum
// by the fill count, SUM_W = 32 + clog2(MAX_WINDOW + 1) (41 at MAX_WINDOW = 256). A new
// sample starts only after OUT, which holds while a result waits on m_tready; skipped
// samples never enter the queue. A two-entry queue sits between classifier and engine.
// Reset (synchronous, aresetn low): window, counters and EMA cleared, N = 14, w = 8738.
`default_nettype none
module sma_ema_price_filter_top #(
    parameter int MAX_WINDOW = 256
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [63:0]                 s_tdata,  // close_price, stamp
    input  wire logic                        s_tuser,  // sample_ok
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [95:0]                      m_tdata,  // out_stamp, mean_price, ema_price
    output logic                             m_tuser,  // ema_present
    input  wire logic                        cfg_we,
    input  wire logic [sef_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [sef_pkg::CFG_DW-1:0]  cfg_wdata
);
    logic [sef_pkg::WL_W-1:0] wl_reg;
    logic [sef_pkg::WT_W-1:0] wt_reg;
    sef_pkg::cfg_bus_t        cfg;
    sef_pkg::q_item_t         push_item;
    sef_pkg::q_item_t         head_item;
    logic                     q_push;
    logic                     q_full;
    logic                     q_pop;
    logic                     q_valid;
    logic                     wl_write;

    assign wl_write = cfg_we && (cfg_addr == sef_pkg::REG_WINDOW_LENGTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg <= sef_pkg::WL_RESET;
            wt_reg <= sef_pkg::WT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                sef_pkg::REG_WINDOW_LENGTH: wl_reg <= cfg_wdata[sef_pkg::WL_W-1:0];
                sef_pkg::REG_EMA_WEIGHT:    wt_reg <= cfg_wdata[sef_pkg::WT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (wl_reg == '0) begin
            cfg.win_len = sef_pkg::WL_W'(1);
        end else if (32'(wl_reg) > 32'(MAX_WINDOW)) begin
            cfg.win_len = sef_pkg::WL_W'(MAX_WINDOW);
        end else begin
            cfg.win_len = wl_reg;
        end
        cfg.weight    = wt_reg;
        cfg.win_clear = wl_write;
    end

    sef_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .sample_ok   (s_tuser),
        .close_price (s_tdata[31:0]),
        .stamp       (s_tdata[63:32]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    sef_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_item  (head_item),
        .head_valid (q_valid)
    );

    sef_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );
endmodule
`default_nettype wire

// File: rtl/sef_ram.sv
`default_nettype none
module sef_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/sef_queue.sv
`default_nettype none
module sef_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire sef_pkg::q_item_t push_item,
    output logic                  full,
    input  wire logic             pop,
    output sef_pkg::q_item_t      head_item,
    output logic                  head_valid
);
    sef_pkg::q_item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/sef_front.sv
`default_nettype none
module sef_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire sef_pkg::cfg_bus_t         cfg,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic                      sample_ok,
    input  wire logic [sef_pkg::PRICE_BITS-1:0] close_price,
    input  wire logic [31:0]               stamp,
    input  wire logic                      q_full,
    output logic                           q_push,
    output sef_pkg::q_item_t               q_item
);
    logic [sef_pkg::IDX_W-1:0] index_reg;
    logic                      prev_ok_reg;
    logic                      accept;
    logic [sef_pkg::IDX_W:0]   pos_ext;
    logic [sef_pkg::IDX_W:0]   len_ext;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && sample_ok;

    assign pos_ext = {1'b0, index_reg};
    assign len_ext = {{(sef_pkg::IDX_W + 1 - sef_pkg::WL_W){1'b0}}, cfg.win_len};

    always_comb begin
        q_item.close   = close_price;
        q_item.stamp   = stamp;
        q_item.emit    = (pos_ext >= len_ext);
        q_item.seed_ok = prev_ok_reg && (pos_ext >= len_ext + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg   <= '0;
            prev_ok_reg <= 1'b0;
        end else if (cfg.win_clear) begin
            prev_ok_reg <= 1'b0;
        end else if (accept) begin
            if (index_reg != sef_pkg::INDEX_TOP) begin
                index_reg <= index_reg + 1'b1;
            end
            prev_ok_reg <= sample_ok;
        end
    end
endmodule
`default_nettype wire

// File: rtl/sef_back.sv
`default_nettype none
module sef_back #(
    parameter int MAX_WINDOW = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sef_pkg::cfg_bus_t cfg,
    input  wire logic              q_valid,
    input  wire sef_pkg::q_item_t  q_item,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [95:0]            m_tdata,
    output logic                   m_tuser
);
    localparam int PB     = sef_pkg::PRICE_BITS;
    localparam int AW     = $clog2(MAX_WINDOW);
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = PB + FILL_W;
    localparam int CNT_W  = $clog2(SUM_W);
    localparam logic [AW-1:0] SLOT_LAST = AW'(MAX_WINDOW - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_UPD   = 3'd2;
    localparam logic [2:0] ST_MULB  = 3'd3;
    localparam logic [2:0] ST_BLEND = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]        state_reg;
    logic [AW-1:0]     slot_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [PB-1:0]     mean_reg;
    logic [PB-1:0]     ema_reg;
    logic              seeded_reg;

    logic [PB-1:0]     close_reg;
    logic [31:0]       stamp_reg;
    logic              emit_reg;
    logic              upd_ema_reg;
    logic [AW-1:0]     old_reg;
    logic [PB-1:0]     y_reg;
    logic [PB+15:0]    prod_a_reg;
    logic [PB+16:0]    prod_b_reg;

    logic [SUM_W-1:0]  num_reg;
    logic [FILL_W-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic              out_valid_reg;
    logic [95:0]       out_data_reg;
    logic              out_user_reg;

    logic [PB-1:0]     old_data;
    logic              ram_re;
    logic              ram_we;
    logic [AW-1:0]     old_next;
    logic              full_win;
    logic [16:0]       w_inv;
    logic [PB+17:0]    blend_sum;
    logic [PB+1:0]     blend_r;
    logic [PB-1:0]     blend_sat;
    logic [FILL_W:0]   rem_sh;
    logic              q_bit;
    logic              out_free;

    assign ram_re = (state_reg == ST_READ);
    assign ram_we = (state_reg == ST_UPD);

    sef_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (close_reg),
        .re    (ram_re),
        .raddr (old_reg),
        .rdata (old_data)
    );

    always_comb begin
        logic [31:0] s;
        logic [31:0] n;
        logic [31:0] t;
        s = 32'(slot_reg);
        n = 32'(cfg.win_len);
        t = (s >= n) ? (s - n) : (s + 32'(MAX_WINDOW) - n);
        old_next = t[AW-1:0];
    end

    assign full_win = (32'(fill_reg) >= 32'(cfg.win_len));

    assign w_inv     = 17'h10000 - {1'b0, cfg.weight};
    assign blend_sum = (PB+18)'(prod_a_reg) + (PB+18)'(prod_b_reg) + (PB+18)'(32768);
    assign blend_r   = blend_sum[PB+17:16];
    assign blend_sat = (blend_r[PB+1:PB] != 2'b00) ? {PB{1'b1}} : blend_r[PB-1:0];

    assign rem_sh = {rem_reg, num_reg[SUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, fill_reg});

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                close_reg   <= q_item.close;
                stamp_reg   <= q_item.stamp;
                emit_reg    <= q_item.emit;
                upd_ema_reg <= seeded_reg || q_item.seed_ok;
                y_reg       <= seeded_reg ? ema_reg : mean_reg;
                old_reg     <= old_next;
            end
            ST_UPD: begin
                prod_a_reg <= (PB+16)'(cfg.weight) * (PB+16)'(close_reg);
            end
            ST_MULB: begin
                prod_b_reg <= (PB+17)'(w_inv) * (PB+17)'(y_reg);
            end
            ST_BLEND: begin
                num_reg <= sum_reg;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DIV: begin
                num_reg <= {num_reg[SUM_W-2:0], q_bit};
                rem_reg <= q_bit ? FILL_W'(rem_sh - {1'b0, fill_reg}) : rem_sh[FILL_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: begin
            end
        endcase
        if (state_reg == ST_OUT && emit_reg && out_free) begin
            out_data_reg <= {(seeded_reg ? ema_reg[31:0] : 32'd0), num_reg[31:0], stamp_reg};
            out_user_reg <= seeded_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            mean_reg      <= '0;
            ema_reg       <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && emit_reg && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.win_clear) begin
                slot_reg <= '0;
                fill_reg <= '0;
                sum_reg  <= '0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    sum_reg  <= sum_reg - (full_win ? SUM_W'(old_data) : '0)
                                + SUM_W'(close_reg);
                    if (!full_win) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    slot_reg  <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                    state_reg <= ST_MULB;
                end
                ST_MULB: begin
                    state_reg <= ST_BLEND;
                end
                ST_BLEND: begin
                    if (upd_ema_reg) begin
                        ema_reg    <= blend_sat;
                        seeded_reg <= 1'b1;
                    end
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (cnt_reg == CNT_W'(SUM_W - 1)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    mean_reg <= num_reg[PB-1:0];
                    if (!emit_reg || out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: verif/sma_ema_price_filter_top_tb.sv
`timescale 1ns / 1ps
module sma_ema_price_filter_top_tb;

    localparam logic [sef_pkg::CFG_AW-1:0] REG_SPARE_A = 2'd2;
    localparam logic [sef_pkg::CFG_AW-1:0] REG_SPARE_B = 2'd3;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_BURSTY} ready_mode_e;

    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] mean;
        logic        present;
        logic [31:0] ema;
    } avg_beat_t;

    class price_average_model;
        logic [31:0] win_store [256];
        logic [7:0]  slot;
        logic [39:0] win_sum;
        logic [8:0]  fill;
        logic [9:0]  pos_count;
        bit          prev_ok;
        logic [31:0] ema;
        bit          seeded;
        logic [8:0]  win_len;
        logic [15:0] weight;
        avg_beat_t   expected_beats [$];
        int          errors;

        function new();
            win_len   = sef_pkg::WL_RESET;
            weight    = sef_pkg::WT_RESET;
            slot      = '0;
            win_sum   = '0;
            fill      = '0;
            pos_count = '0;
            prev_ok   = 0;
            ema       = '0;
            seeded    = 0;
            errors    = 0;
        endfunction

        function logic [8:0] eff_len();
            if (win_len == 9'd0) return 9'd1;
            if (win_len > 9'd256) return 9'd256;
            return win_len;
        endfunction

        function logic [31:0] mean_now();
            logic [39:0] q;
            if (fill == 9'd0) return 32'd0;
            q = win_sum / {31'd0, fill};
            return q[31:0];
        endfunction

        function logic [31:0] blend(logic [31:0] x, logic [31:0] y);
            logic [63:0] w64;
            logic [63:0] r;
            w64 = {48'd0, weight};
            r = (w64 * {32'd0, x} + (64'd65536 - w64) * {32'd0, y} + 64'd32768) >> 16;
            if (r > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
            return r[31:0];
        endfunction

        function void write_reg(logic [sef_pkg::CFG_AW-1:0] idx,
                                logic [sef_pkg::CFG_DW-1:0] val);
            if (idx == sef_pkg::REG_WINDOW_LENGTH) begin
                win_len = val[8:0];
                slot    = '0;
                win_sum = '0;
                fill    = '0;
                prev_ok = 0;
            end else if (idx == sef_pkg::REG_EMA_WEIGHT) begin
                weight = val[15:0];
            end
        endfunction

        function void take_sample(bit ok, logic [31:0] close, logic [31:0] stamp);
            logic [9:0] pos;
            logic [8:0] n;
            logic [7:0] old;
            avg_beat_t  b;
            pos = pos_count;
            n = eff_len();
            if (pos_count != sef_pkg::INDEX_TOP) pos_count = pos_count + 10'd1;
            if (!ok) begin
                prev_ok = 0;
                return;
            end
            if (!seeded) begin
                if (prev_ok && pos >= ({1'b0, n} + 10'd1)) begin
                    ema = blend(close, mean_now());
                    seeded = 1;
                end
            end else begin
                ema = blend(close, ema);
            end
            if (fill >= n) begin
                old = slot - n[7:0];
                win_sum = win_sum - {8'd0, win_store[old]};
            end else begin
                fill = fill + 9'd1;
            end
            win_store[slot] = close;
            win_sum = win_sum + {8'd0, close};
            slot = slot + 8'd1;
            prev_ok = 1;
            if (pos >= {1'b0, n}) begin
                b.stamp   = stamp;
                b.mean    = mean_now();
                b.present = seeded;
                b.ema     = seeded ? ema : 32'd0;
                expected_beats = {expected_beats, b};
            end
        endfunction

        function void check_beat(logic [31:0] stamp, logic [31:0] mean, logic present,
                                 logic [31:0] ema_act);
            avg_beat_t b;
            if (expected_beats.size() == 0) begin
                if (errors < 10)
                    $display("unexpected beat: stamp %h mean %h present %b ema %h",
                             stamp, mean, present, ema_act);
                errors++;
                return;
            end
            b = expected_beats.pop_front();
            if (stamp !== b.stamp || mean !== b.mean || present !== b.present ||
                ema_act !== b.ema) begin
                if (errors < 10)
                    $display("mismatch: exp stamp %h mean %h present %b ema %h / act %h %h %b %h",
                             b.stamp, b.mean, b.present, b.ema, stamp, mean, present, ema_act);
                errors++;
            end
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [63:0]                  s_tdata;
    logic                         s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [95:0]                  m_tdata;
    logic                         m_tuser;
    logic                         cfg_we;
    logic [sef_pkg::CFG_AW-1:0]   cfg_addr;
    logic [sef_pkg::CFG_DW-1:0]   cfg_wdata;

    price_average_model sb;
    int cycle_count;
    ready_mode_e rdy_mode;

    sma_ema_price_filter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[sma_ema_price_filter_top] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.take_sample(s_tuser, s_tdata[31:0], s_tdata[63:32]);
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata[31:0], m_tdata[63:32], m_tuser, m_tdata[95:64]);
            if (cfg_we)
                sb.write_reg(cfg_addr, cfg_wdata);
        end
    end

    // receiver backpressure, own pattern
    initial begin
        int span;
        int hold;
        m_tready = 1'b0;
        hold = 0;
        forever begin
            rdy_mode = ready_mode_e'($urandom_range(0, 3));
            span = $urandom_range(50, 400);
            repeat (span) begin
                @(negedge aclk);
                case (rdy_mode)
                    RDY_ALWAYS: m_tready = 1'b1;
                    RDY_COIN:   m_tready = 1'($urandom_range(0, 1));
                    RDY_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
                    default: begin
                        if (hold == 0) begin
                            m_tready = !m_tready;
                            hold = $urandom_range(0, 8);
                        end else begin
                            hold--;
                        end
                    end
                endcase
            end
        end
    end

    task automatic push_sample(bit ok, logic [31:0] close, logic [31:0] stamp);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = ok;
        s_tdata  = {stamp, close};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tuser  = 1'($urandom_range(0, 1));
            s_tdata  = {$urandom, $urandom};
        end
    endtask

    task automatic set_reg(logic [sef_pkg::CFG_AW-1:0] addr,
                           logic [sef_pkg::CFG_DW-1:0] data);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
    endtask

    task automatic wait_drain(int extra);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.expected_beats.size() != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic random_sample();
        bit ok;
        logic [31:0] c;
        ok = ($urandom_range(0, 99) >= 12);
        case ($urandom_range(0, 9))
            0: c = 32'd0;
            1: c = 32'hFFFF_FFFF;
            2: c = $urandom_range(0, 255);
            3: c = 32'hFFFF_FF00 | $urandom_range(0, 255);
            default: c = $urandom;
        endcase
        push_sample(ok, c, $urandom);
    endtask

    function automatic logic [8:0] pick_len();
        case ($urandom_range(0, 7))
            0: return 9'd0;
            1: return 9'd1;
            2: return 9'd2;
            3: return 9'd256;
            4: return 9'($urandom_range(257, 511));
            5, 6: return 9'($urandom_range(3, 20));
            default: return 9'($urandom_range(21, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_wt();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(int items, bit set_len, bit set_wt, logic [8:0] len,
                             logic [15:0] wt, bit mid_pause);
        int burst_left;
        int gap;
        int i;
        burst_left = 0;
        wait_drain(SETTLE_CYCLES);
        if (set_len) set_reg(sef_pkg::REG_WINDOW_LENGTH, {7'd0, len});
        if (set_wt) set_reg(sef_pkg::REG_EMA_WEIGHT, wt);
        for (i = 0; i < items; i++) begin
            if (mid_pause && i == items / 2) wait_drain(0);
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                idle_cycles(gap);
            end
            burst_left--;
            random_sample();
        end
    endtask

    initial begin
        int p;
        int sel;
        sb = new();
        cycle_count = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // short window, full weight, spare indexes ignored
        set_reg(sef_pkg::REG_WINDOW_LENGTH, 16'd3);
        set_reg(sef_pkg::REG_EMA_WEIGHT, 16'hFFFF);
        set_reg(REG_SPARE_A, 16'hFFFF);
        set_reg(REG_SPARE_B, 16'h0001);
        push_sample(1, 32'd0, 32'd0);
        push_sample(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_sample(1, 32'hFFFF_FFFF, 32'd1);
        push_sample(1, 32'h0100_0000, 32'd2);
        push_sample(0, 32'h0, 32'd5);
        push_sample(1, 32'hFFFF_FFFF, 32'd3);   // predecessor skipped: no seed
        push_sample(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_sample(1, 32'd0, 32'd4);
        push_sample(1, 32'h8000_0000, 32'd6);

        // zero length acts as one
        wait_drain(SETTLE_CYCLES);
        set_reg(sef_pkg::REG_WINDOW_LENGTH, 16'd0);
        set_reg(sef_pkg::REG_EMA_WEIGHT, 16'd0);
        push_sample(1, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        push_sample(1, 32'd0, 32'h5A5A_A5A5);
        push_sample(0, 32'hFFFF_FFFF, 32'd7);
        push_sample(1, 32'hFFFF_FFFF, 32'd8);

        // oversize length clamps to the store depth
        wait_drain(SETTLE_CYCLES);
        set_reg(sef_pkg::REG_WINDOW_LENGTH, 16'd511);
        set_reg(sef_pkg::REG_EMA_WEIGHT, 16'd32768);
        push_sample(1, 32'h1234_5678, 32'd9);
        push_sample(1, 32'hFFFF_FFFF, 32'd10);
        push_sample(1, 32'd0, 32'd11);
        push_sample(1, 32'hFFFF_FFFF, 32'd12);

        // full-depth window to exercise ring wrap
        run_phase(360, 1, 1, 9'd256, pick_wt(), 0);
        for (p = 0; p < 8; p++) begin
            sel = $urandom_range(0, 3);
            run_phase(160, sel != 0, sel != 1, pick_len(), pick_wt(), p == 3);
        end

        wait_drain(SETTLE_CYCLES);
        if (sb.errors == 0) begin
            $display("[sma_ema_price_filter_top] OK");
        end else begin
            $display("[sma_ema_price_filter_top] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/sef_pkg.sv
rtl/sef_ram.sv
rtl/sef_queue.sv
rtl/sef_front.sv
rtl/sef_back.sv
rtl/sma_ema_price_filter_top.sv
verif/sma_ema_price_filter_top_tb.sv
